// ===== sv/chssl_pkg.sv =====
// Package holding the types, sizes and codes shared by the set lookup block.
package chssl_pkg;

  localparam int unsigned MaxEntries = 1024;
  localparam int unsigned AddrW      = $clog2(MaxEntries);
  localparam int unsigned CountW     = $clog2(MaxEntries + 1);
  localparam int unsigned TotalW     = 11;
  localparam logic [31:0] CrcPoly    = 32'hEDB88320;

  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpSeal  = 2'd2;

  localparam logic [1:0] KindLoad  = 2'd0;
  localparam logic [1:0] KindQuery = 2'd1;
  localparam logic [1:0] KindSeal  = 2'd2;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatFull  = 2'd1;
  localparam logic [1:0] StatEmpty = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  answer_kind;
    logic [1:0]  status;
    logic        found;
    logic [31:0] hash_value;
    logic [TotalW-1:0] entry_total;
  } out_beat_t;

  // Datapath commands.
  typedef struct packed {
    logic              crc_step;   // fold the input byte into the running CRC
    logic              crc_clear;
    logic              append;     // write hash at entry_count, bump count
    logic              rd_en;
    logic [AddrW-1:0]  rd_addr;
    logic              wr_en;
    logic [AddrW-1:0]  wr_addr;
    logic              wr_sel_hold; // write the held key instead of read data
    logic              hold_load;   // capture read data as held key
    logic              key_load;    // capture the finished hash as search key
    logic              seal_set;
  } dp_cmd_t;

  typedef struct packed {
    logic [31:0]       hash;       // finished hash of current byte
    logic [31:0]       key;
    logic [31:0]       hold;
    logic [31:0]       rd_data;
    logic [CountW-1:0] count;
    logic              sealed;
  } dp_stat_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/chssl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module chssl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== sv/chssl_datapath.sv =====
// Datapath: running CRC, entry count, seal flag, search key and entry memory.
module chssl_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           data_byte_i,
  input  chssl_pkg::dp_cmd_t   cmd_i,
  output chssl_pkg::dp_stat_t  stat_o
);

  logic [31:0] crc_q, crc_d, crc_next;
  logic [chssl_pkg::CountW-1:0] count_q;
  logic sealed_q;
  logic [31:0] key_q, hold_q, rd_data, wr_data;
  logic [chssl_pkg::AddrW-1:0] wr_addr;

  assign crc_next = chssl_pkg::crc_byte(crc_q, data_byte_i);

  always_comb begin
    crc_d = crc_q;
    if (cmd_i.crc_clear) begin
      crc_d = '0;
    end else if (cmd_i.crc_step) begin
      crc_d = crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= '0;
      count_q  <= '0;
      sealed_q <= 1'b0;
    end else begin
      crc_q <= crc_d;
      if (cmd_i.append) begin
        count_q  <= count_q + 1'b1;
        sealed_q <= 1'b0;
      end else if (cmd_i.seal_set) begin
        sealed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_load) begin
      key_q <= ~crc_next;
    end
    if (cmd_i.hold_load) begin
      hold_q <= rd_data;
    end
  end

  assign wr_addr = cmd_i.append ? count_q[chssl_pkg::AddrW-1:0] : cmd_i.wr_addr;
  assign wr_data = cmd_i.append ? ~crc_next :
                   (cmd_i.wr_sel_hold ? hold_q : rd_data);

  chssl_ram #(
    .Width(32),
    .Depth(chssl_pkg::MaxEntries)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en | cmd_i.append),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (cmd_i.rd_addr),
    .rd_data_o (rd_data)
  );

  assign stat_o.hash    = ~crc_next;
  assign stat_o.key     = key_q;
  assign stat_o.hold    = hold_q;
  assign stat_o.rd_data = rd_data;
  assign stat_o.count   = count_q;
  assign stat_o.sealed  = sealed_q;

endmodule

// ===== sv/chssl_ctrl.sv =====
// Controller: byte handling, insertion sort sequencer and binary search sequencer.
module chssl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  chssl_pkg::in_beat_t  in_i,
  output logic                 busy_o,
  output logic                 done_o,
  output chssl_pkg::out_beat_t result_o,
  output chssl_pkg::dp_cmd_t   cmd_o,
  input  chssl_pkg::dp_stat_t  stat_i
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSortRd = 3'd1; // read entry i into hold
  localparam logic [2:0] StSortCmp= 3'd2; // read j-1, or place hold when j is 0
  localparam logic [2:0] StSortMv = 3'd3; // compare result, shift or place
  localparam logic [2:0] StSrchRd = 3'd4;
  localparam logic [2:0] StSrchCmp= 3'd5;
  localparam logic [2:0] StSortLd = 3'd6;

  localparam int unsigned CW = chssl_pkg::CountW;
  localparam int unsigned AW = chssl_pkg::AddrW;

  logic [2:0] state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0] mid;
  logic done_d;
  chssl_pkg::out_beat_t res_q, res_d;
  logic accept;

  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);
  assign mid    = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    lo_d = lo_q;
    hi_d = hi_q;
    done_d = 1'b0;
    res_d = res_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          res_d.found = 1'b0;
          res_d.status = chssl_pkg::StatOk;
          res_d.hash_value = stat_i.hash;
          res_d.entry_total = stat_i.count[chssl_pkg::TotalW-1:0];
          unique case (in_i.opcode)
            chssl_pkg::OpSeal: begin
              cmd_o.crc_clear = 1'b1;
              res_d.answer_kind = chssl_pkg::KindSeal;
              res_d.hash_value = '0;
              i_d = CW'(1);
              state_d = StSortLd;
            end
            chssl_pkg::OpLoad, chssl_pkg::OpQuery: begin
              cmd_o.crc_step = 1'b1;
              if (in_i.last_byte) begin
                cmd_o.crc_clear = 1'b1;
                if (in_i.opcode == chssl_pkg::OpLoad) begin
                  res_d.answer_kind = chssl_pkg::KindLoad;
                  done_d = 1'b1;
                  if (stat_i.count < CW'(chssl_pkg::MaxEntries)) begin
                    cmd_o.append = 1'b1;
                    res_d.entry_total = chssl_pkg::TotalW'(stat_i.count + 1'b1);
                  end else begin
                    res_d.status = chssl_pkg::StatFull;
                  end
                end else begin
                  res_d.answer_kind = chssl_pkg::KindQuery;
                  if (!stat_i.sealed || stat_i.count == '0) begin
                    res_d.status = chssl_pkg::StatEmpty;
                    done_d = 1'b1;
                  end else begin
                    cmd_o.key_load = 1'b1;
                    lo_d = '0;
                    hi_d = stat_i.count;
                    state_d = StSrchRd;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      StSortLd: begin
        if (i_q >= stat_i.count) begin
          cmd_o.seal_set = 1'b1;
          done_d = 1'b1;
          state_d = StIdle;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_addr = i_q[AW-1:0];
          state_d = StSortRd;
        end
      end
      StSortRd: begin
        cmd_o.hold_load = 1'b1;
        j_d = i_q;
        state_d = StSortCmp;
      end
      StSortCmp: begin
        if (j_q == '0) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.wr_sel_hold = 1'b1;
          cmd_o.wr_addr = j_q[AW-1:0];
          i_d = i_q + 1'b1;
          state_d = StSortLd;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_addr = AW'(j_q - 1'b1);
          state_d = StSortMv;
        end
      end
      StSortMv: begin
        if (stat_i.rd_data > stat_i.hold) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.wr_addr = j_q[AW-1:0];
          j_d = j_q - 1'b1;
          state_d = StSortCmp;
        end else begin
          cmd_o.wr_en = 1'b1;
          cmd_o.wr_sel_hold = 1'b1;
          cmd_o.wr_addr = j_q[AW-1:0];
          i_d = i_q + 1'b1;
          state_d = StSortLd;
        end
      end
      StSrchRd: begin
        if (lo_q >= hi_q) begin
          done_d = 1'b1;
          state_d = StIdle;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_addr = mid[AW-1:0];
          state_d = StSrchCmp;
        end
      end
      StSrchCmp: begin
        if (stat_i.rd_data == stat_i.key) begin
          res_d.found = 1'b1;
          done_d = 1'b1;
          state_d = StIdle;
        end else begin
          if (stat_i.rd_data > stat_i.key) begin
            hi_d = mid;
          end else begin
            lo_d = mid + 1'b1;
          end
          state_d = StSrchRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    res_q <= res_d;
  end

  assign result_o = res_q;

endmodule

// ===== sv/crc_hashed_sorted_set_lookup.sv =====
// Top level of the CRC hashed sorted set lookup block (CRC-32 polynomial, zero start value).
// A string byte is accepted while busy is low, and busy stays low except after the last byte
// of a query that has to search and after a seal. A finished load, and a query answered as
// empty or unsealed, answers in the cycle after its byte. A searching query walks a binary
// search over the stored hashes, each probe reading the entry memory through its read port.
// Seal runs an insertion sort over the n entries through the same single read and write port,
// holding each entry and shifting larger ones up. A search or seal answers in the cycle in
// which busy falls. Results appear on result_o for one cycle with done_o high and cannot be
// held off by the receiver.
module crc_hashed_sorted_set_lookup (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  chssl_pkg::in_beat_t  item_i,
  output logic                 done_o,
  output chssl_pkg::out_beat_t result_o
);

  chssl_pkg::dp_cmd_t  cmd;
  chssl_pkg::dp_stat_t stat;

  chssl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .in_i     (item_i),
    .busy_o   (busy),
    .done_o   (done_o),
    .result_o (result_o),
    .cmd_o    (cmd),
    .stat_i   (stat)
  );

  chssl_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (item_i.data_byte),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ===== tb/chssl_checker.sv =====
// Checker that predicts the set lookup block's answers and compares them with its outputs.
`timescale 1ns / 1ps
module chssl_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  chssl_pkg::in_beat_t  item_i,
  input  logic                 done_o,
  input  chssl_pkg::out_beat_t result_o,
  output int                   fail_count,
  output int                   pending_count
);

  logic [31:0]                  table_model [chssl_pkg::MaxEntries];
  logic [chssl_pkg::CountW-1:0] stored_total;
  logic [31:0]                  crc_state;
  logic                         table_sealed;
  chssl_pkg::out_beat_t         answer_queue [$];

  assign pending_count = answer_queue.size();

  function automatic logic [31:0] fold_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
    end
    return r;
  endfunction

  task automatic sort_entries();
    logic [31:0] v;
    int j;
    for (int i = 1; i < int'(stored_total); i++) begin
      v = table_model[i];
      j = i;
      while (j > 0 && table_model[j-1] > v) begin
        table_model[j] = table_model[j-1];
        j--;
      end
      table_model[j] = v;
    end
  endtask

  function automatic logic search_entries(logic [31:0] h);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = int'(stored_total);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_model[mid] == h) return 1'b1;
      if (table_model[mid] > h) hi = mid;
      else lo = mid + 1;
    end
    return 1'b0;
  endfunction

  task automatic predict_beat(chssl_pkg::in_beat_t b);
    chssl_pkg::out_beat_t e;
    e = '0;
    if (b.opcode == chssl_pkg::OpSeal) begin
      crc_state = '0;
      sort_entries();
      table_sealed = 1'b1;
      e.answer_kind = chssl_pkg::KindSeal;
      e.status = chssl_pkg::StatOk;
    end else if (b.opcode == chssl_pkg::OpLoad || b.opcode == chssl_pkg::OpQuery) begin
      crc_state = fold_byte(crc_state, b.data_byte);
      if (!b.last_byte) return;
      e.hash_value = crc_state ^ 32'hFFFFFFFF;
      crc_state = '0;
      if (b.opcode == chssl_pkg::OpLoad) begin
        e.answer_kind = chssl_pkg::KindLoad;
        if (stored_total < chssl_pkg::MaxEntries) begin
          table_model[stored_total] = e.hash_value;
          stored_total++;
          table_sealed = 1'b0;
        end else begin
          e.status = chssl_pkg::StatFull;
        end
      end else begin
        e.answer_kind = chssl_pkg::KindQuery;
        if (!table_sealed || stored_total == 0) e.status = chssl_pkg::StatEmpty;
        else e.found = search_entries(e.hash_value);
      end
    end else begin
      return;
    end
    e.entry_total = stored_total[chssl_pkg::TotalW-1:0];
    answer_queue.push_back(e);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    chssl_pkg::out_beat_t e;
    if (!rst_ni) begin
      stored_total = '0;
      crc_state = '0;
      table_sealed = 1'b0;
      fail_count <= 0;
      answer_queue.delete();
    end else begin
      if (done_o) begin
        if (answer_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("Unexpected result beat %p", result_o);
        end else begin
          e = answer_queue.pop_front();
          if (result_o !== e) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("Mismatch: expected %p, got %p", e, result_o);
          end
        end
      end
      if (start && !busy) predict_beat(item_i);
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps
module testbench;

  localparam logic [1:0] OpUnused = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  chssl_pkg::in_beat_t  item_i;
  logic                 done_o;
  chssl_pkg::out_beat_t result_o;
  int                   fail_count;
  int                   pending_count;

  crc_hashed_sorted_set_lookup u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o)
  );

  chssl_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .done_o(done_o), .result_o(result_o), .fail_count(fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic send_beat(logic [1:0] op, logic [7:0] b, logic lst, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= '{opcode: op, data_byte: b, last_byte: lst};
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic send_string(logic [1:0] op, int len, bit gaps);
    for (int i = 0; i < len; i++) begin
      send_beat(($urandom_range(0, 9) == 0) ? ~op & 2'd1 : op, 8'($urandom_range(0, 255)),
                i == len - 1, gaps);
    end
  endtask

  initial begin
    int r;
    bit gaps;
    start = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_beat(chssl_pkg::OpQuery, 8'h00, 1'b1, 1'b0);
    send_beat(chssl_pkg::OpSeal, 8'h00, 1'b0, 1'b0);
    send_beat(chssl_pkg::OpQuery, 8'hFF, 1'b1, 1'b0);
    send_beat(chssl_pkg::OpLoad, 8'h00, 1'b0, 1'b0);
    send_beat(chssl_pkg::OpLoad, 8'hFF, 1'b1, 1'b0);
    send_beat(chssl_pkg::OpQuery, 8'h00, 1'b0, 1'b0);
    send_beat(chssl_pkg::OpQuery, 8'hFF, 1'b1, 1'b0);
    send_beat(OpUnused, 8'hA5, 1'b1, 1'b0);
    send_beat(chssl_pkg::OpLoad, 8'h5A, 1'b0, 1'b0);
    send_beat(chssl_pkg::OpQuery, 8'hA5, 1'b1, 1'b0);
    send_beat(chssl_pkg::OpLoad, 8'h33, 1'b0, 1'b0);
    send_beat(chssl_pkg::OpSeal, 8'h00, 1'b1, 1'b0);
    send_beat(chssl_pkg::OpLoad, 8'h00, 1'b1, 1'b0);
    send_beat(chssl_pkg::OpSeal, 8'hFF, 1'b1, 1'b0);
    send_beat(chssl_pkg::OpLoad, 8'hFF, 1'b1, 1'b0);
    send_beat(chssl_pkg::OpQuery, 8'hFF, 1'b1, 1'b0);
    send_beat(chssl_pkg::OpQuery, 8'h00, 1'b1, 1'b0);
    send_beat(chssl_pkg::OpSeal, 8'h00, 1'b0, 1'b0);
    send_beat(chssl_pkg::OpQuery, 8'hFF, 1'b1, 1'b0);
    send_beat(chssl_pkg::OpQuery, 8'h00, 1'b1, 1'b0);
    for (int n = 0; n < 370; n++) begin
      gaps = (n / 100) % 2 == 0;
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_string(chssl_pkg::OpLoad, $urandom_range(1, 3), gaps);
      end else if (r < 85) begin
        send_string(chssl_pkg::OpQuery, $urandom_range(1, 3), gaps);
      end else if (r < 93) begin
        send_beat(chssl_pkg::OpSeal, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  gaps);
      end else begin
        send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), gaps);
      end
    end
    send_beat(chssl_pkg::OpSeal, 8'h00, 1'b0, 1'b0);
    for (int n = 0; n < 30; n++) send_string(chssl_pkg::OpQuery, 1, 1'b1);
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
